@@ src/kabf_pkg.sv @@
// ----------------------------------------------------------------------------
// kabf_pkg
// shared types, constants and helpers for the angle/bias kalman filter
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC            = 24;
    localparam int REG_W           = 31;
    localparam int CFG_IDX_W       = 2;

    localparam logic [REG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
    localparam logic [REG_W-1:0] BIAS_NOISE_RST  = 31'd50331;
    localparam logic [REG_W-1:0] MEAS_NOISE_RST  = 31'd503316;
    localparam logic signed [31:0] ONE_Q24       = 32'sd16777216;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE    = 5'd0,
        OP_LOAD    = 5'd1,
        OP_PRED_A  = 5'd2,   // angle += dt*(rate-bias)
        OP_DT_P11  = 5'd3,   // t0 = dt*p11 - p01 - p10 + qa
        OP_INNER   = 5'd4,   // t1 = dt*t0
        OP_P00     = 5'd5,
        OP_P01     = 5'd6,
        OP_P11     = 5'd7,   // t2 = qb*dt, p11 update
        OP_DIV0    = 5'd8,   // start k0 divide
        OP_DIV1    = 5'd9,   // start k1 divide
        OP_INNOV   = 5'd10,
        OP_COR_A   = 5'd11,
        OP_COR_B   = 5'd12,
        OP_C00     = 5'd13,
        OP_C01     = 5'd14,
        OP_C10     = 5'd15,
        OP_C11     = 5'd16,
        OP_COMMIT  = 5'd17
    } op_t;

    typedef struct packed {
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_stat_t;

    // saturate a 66-bit signed value to w bits (w <= 32)
    function automatic logic [32:0] sat_w(input logic signed [65:0] v, input int w);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        logic [32:0]        r;
        hi = (66'sd1 <<< (w - 1)) - 66'sd1;
        lo = -hi - 66'sd1;
        if (v > hi)      r = {1'b1, hi[31:0]};
        else if (v < lo) r = {1'b1, lo[31:0]};
        else             r = {1'b0, v[31:0]};
        return r;
    endfunction

    // floor((p + 2^23) / 2^24)
    function automatic logic signed [65:0] rnd24(input logic signed [65:0] p);
        logic signed [65:0] q;
        q = p + (66'sd1 <<< (FRAC - 1));
        return q >>> FRAC;
    endfunction

endpackage

@@ src/kabf_div.sv @@
// ----------------------------------------------------------------------------
// kabf_div
// signed restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module kabf_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [56:0] dividend,
    input  logic signed [32:0] divisor,
    output logic               busy,
    output logic signed [57:0] quotient
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [56:0] num_reg, num_next;
    logic [57:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [57:0] trial;
    logic [56:0] num_abs;
    logic [32:0] den_abs;

    assign num_abs = dividend[56] ? 57'(-dividend) : 57'(dividend);
    assign den_abs = divisor[32] ? 33'(-divisor) : 33'(divisor);
    assign trial   = {rem_reg[56:0], num_reg[56]} - {25'd0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        if (start)
        begin
            cnt_next = 6'd57;
            num_next = num_abs;
            rem_next = '0;
            den_next = den_abs;
            neg_next = dividend[56] ^ divisor[32];
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[57])
            begin
                rem_next = trial;
                num_next = {num_reg[55:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[56:0], num_reg[56]};
                num_next = {num_reg[55:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

endmodule

@@ src/kabf_datapath.sv @@
// ----------------------------------------------------------------------------
// kabf_datapath
// state registers, shared multiplier and divider for the filter
// ----------------------------------------------------------------------------
module kabf_datapath
#(
    parameter int VALUE_WIDTH = kabf_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kabf_pkg::dp_cmd_t             cmd,
    output kabf_pkg::dp_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [kabf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [kabf_pkg::REG_W-1:0]    cfg_data,
    input  logic signed [31:0]            measured_angle,
    input  logic signed [31:0]            gyro_rate,
    input  logic [23:0]                   time_step,
    output logic signed [31:0]            angle_estimate,
    output logic signed [31:0]            bias_estimate,
    output logic                          saturated
);

    localparam int VW = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);

    logic [kabf_pkg::REG_W-1:0] qa_reg, qb_reg, rm_reg;
    logic signed [31:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [31:0] c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [31:0] c00_next, c01_next, c10_next, c11_next;
    logic signed [31:0] meas_reg, rate_reg, meas_next, rate_next;
    logic [23:0]        dt_reg, dt_next;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] p00_next, p01_next, p10_next, p11_next;
    logic signed [31:0] k0_reg, k1_reg, k0_next, k1_next, y_reg, y_next;
    logic signed [65:0] t_reg, t_next;
    logic               sat_reg, sat_next, szero_reg, szero_next;
    logic               out_sat_reg;
    logic signed [31:0] out_a_reg, out_b_reg;

    // shared multiplier
    logic signed [33:0] ma, mb;
    logic signed [65:0] prod, rp;

    logic               div_start;
    logic signed [56:0] div_num;
    logic signed [32:0] s_val;
    logic signed [57:0] div_q;
    logic               div_busy;
    logic [32:0]        sv;
    logic [32:0]        sv2;
    logic signed [65:0] sum;

    assign s_val = 33'(p00_reg) + $signed({2'b00, rm_reg});

    kabf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (s_val),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign stat.div_busy = div_busy;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            kabf_pkg::OP_PRED_A: begin ma = {10'd0, dt_reg}; mb = 34'(rate_reg) - 34'(bias_reg); end
            kabf_pkg::OP_DT_P11: begin ma = {10'd0, dt_reg}; mb = 34'(c11_reg); end
            kabf_pkg::OP_INNER:  begin ma = {10'd0, dt_reg}; mb = t_reg[33:0]; end
            kabf_pkg::OP_P01:    begin ma = {10'd0, dt_reg}; mb = 34'(c11_reg); end
            kabf_pkg::OP_P11:    begin ma = {3'd0, qb_reg}; mb = {10'd0, dt_reg}; end
            kabf_pkg::OP_COR_A:  begin ma = 34'(k0_reg); mb = 34'(y_reg); end
            kabf_pkg::OP_COR_B:  begin ma = 34'(k1_reg); mb = 34'(y_reg); end
            kabf_pkg::OP_C00:    begin ma = 34'(k0_reg); mb = 34'(p00_reg); end
            kabf_pkg::OP_C01:    begin ma = 34'(k0_reg); mb = 34'(p01_reg); end
            kabf_pkg::OP_C10:    begin ma = 34'(k1_reg); mb = 34'(p00_reg); end
            kabf_pkg::OP_C11:    begin ma = 34'(k1_reg); mb = 34'(p01_reg); end
            default:             begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = 66'(ma) * 66'(mb);
    assign rp   = kabf_pkg::rnd24(prod);

    always_comb
    begin
        ang_next = ang_reg;   bias_next = bias_reg;
        c00_next = c00_reg;   c01_next = c01_reg;
        c10_next = c10_reg;   c11_next = c11_reg;
        meas_next = meas_reg; rate_next = rate_reg; dt_next = dt_reg;
        p00_next = p00_reg;   p01_next = p01_reg;
        p10_next = p10_reg;   p11_next = p11_reg;
        k0_next = k0_reg;     k1_next = k1_reg; y_next = y_reg;
        t_next = t_reg;       sat_next = sat_reg; szero_next = szero_reg;
        div_start = 1'b0;
        div_num = '0;
        sv = '0;
        sv2 = '0;
        sum = '0;
        case (cmd.op)
            kabf_pkg::OP_LOAD:
            begin
                meas_next = measured_angle;
                rate_next = gyro_rate;
                dt_next   = time_step;
                sat_next  = 1'b0;
            end
            kabf_pkg::OP_PRED_A:
            begin
                sum = 66'(ang_reg) + rp;
                sv = kabf_pkg::sat_w(sum, VW);
                ang_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_DT_P11:
            begin
                // inner term t0 = dt*p11 - p01 - p10 + qa, kept in t
                t_next = rp - 66'(c01_reg) - 66'(c10_reg) + $signed({35'd0, qa_reg});
            end
            kabf_pkg::OP_INNER:
                t_next = rp;
            kabf_pkg::OP_P00:
            begin
                sum = 66'(c00_reg) + t_reg;
                sv = kabf_pkg::sat_w(sum, 32);
                p00_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_P01:
            begin
                sum = 66'(c01_reg) - rp;
                sv = kabf_pkg::sat_w(sum, 32);
                p01_next = sv[31:0];
                sv2 = kabf_pkg::sat_w(66'(c10_reg) - rp, 32);
                p10_next = sv2[31:0];
                sat_next = sat_reg | sv[32] | sv2[32];
            end
            kabf_pkg::OP_P11:
            begin
                sum = 66'(c11_reg) + rp;
                sv = kabf_pkg::sat_w(sum, 32);
                p11_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_DIV0:
            begin
                szero_next = (s_val == 33'sd0);
                div_num = 57'(p00_reg) <<< kabf_pkg::FRAC;
                div_start = 1'b1;
            end
            kabf_pkg::OP_DIV1:
            begin
                sv = kabf_pkg::sat_w(66'(div_q), 32);
                k0_next = szero_reg ? 32'sd0 : sv[31:0];
                sat_next = sat_reg | (szero_reg ? 1'b1 : sv[32]);
                div_num = 57'(p10_reg) <<< kabf_pkg::FRAC;
                div_start = 1'b1;
            end
            kabf_pkg::OP_INNOV:
            begin
                sv = kabf_pkg::sat_w(66'(div_q), 32);
                k1_next = szero_reg ? 32'sd0 : sv[31:0];
                sum = 66'(meas_reg) - 66'(ang_reg);
                sv2 = kabf_pkg::sat_w(sum, 32);
                y_next = sv2[31:0];
                sat_next = sat_reg | (szero_reg ? 1'b0 : sv[32]) | sv2[32];
            end
            kabf_pkg::OP_COR_A:
            begin
                sv = kabf_pkg::sat_w(66'(ang_reg) + rp, VW);
                ang_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_COR_B:
            begin
                sv = kabf_pkg::sat_w(66'(bias_reg) + rp, VW);
                bias_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_C00:
            begin
                sv = kabf_pkg::sat_w(66'(p00_reg) - rp, 32);
                c00_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_C01:
            begin
                sv = kabf_pkg::sat_w(66'(p01_reg) - rp, 32);
                c01_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_C10:
            begin
                sv = kabf_pkg::sat_w(66'(p10_reg) - rp, 32);
                c10_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            kabf_pkg::OP_C11:
            begin
                sv = kabf_pkg::sat_w(66'(p11_reg) - rp, 32);
                c11_next = sv[31:0];
                sat_next = sat_reg | sv[32];
            end
            default:
            begin
                sv = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg   <= kabf_pkg::ANGLE_NOISE_RST;
            qb_reg   <= kabf_pkg::BIAS_NOISE_RST;
            rm_reg   <= kabf_pkg::MEAS_NOISE_RST;
            ang_reg  <= '0;
            bias_reg <= '0;
            c00_reg  <= kabf_pkg::ONE_Q24;
            c01_reg  <= '0;
            c10_reg  <= '0;
            c11_reg  <= kabf_pkg::ONE_Q24;
        end
        else
        begin
            if (cfg_we && cfg_idx == kabf_pkg::CFG_ANGLE_NOISE) qa_reg <= cfg_data;
            if (cfg_we && cfg_idx == kabf_pkg::CFG_BIAS_NOISE)  qb_reg <= cfg_data;
            if (cfg_we && cfg_idx == kabf_pkg::CFG_MEAS_NOISE)  rm_reg <= cfg_data;
            ang_reg  <= ang_next;
            bias_reg <= bias_next;
            c00_reg  <= c00_next;
            c01_reg  <= c01_next;
            c10_reg  <= c10_next;
            c11_reg  <= c11_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg <= meas_next; rate_reg <= rate_next; dt_reg <= dt_next;
        p00_reg <= p00_next; p01_reg <= p01_next; p10_reg <= p10_next; p11_reg <= p11_next;
        k0_reg <= k0_next; k1_reg <= k1_next; y_reg <= y_next;
        t_reg <= t_next; sat_reg <= sat_next; szero_reg <= szero_next;
        if (cmd.op == kabf_pkg::OP_COMMIT)
        begin
            out_a_reg   <= ang_reg;
            out_b_reg   <= bias_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign angle_estimate = out_a_reg;
    assign bias_estimate  = out_b_reg;
    assign saturated      = out_sat_reg;

endmodule

@@ src/kabf_ctrl.sv @@
// ----------------------------------------------------------------------------
// kabf_ctrl
// sequencer issuing datapath operations and running the handshakes
// ----------------------------------------------------------------------------
module kabf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  kabf_pkg::dp_stat_t stat,
    output kabf_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_DONE = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    kabf_pkg::op_t op_reg, op_next;
    logic          ov_reg, ov_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ov_next    = ov_reg;
        cmd.op     = kabf_pkg::OP_NONE;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = kabf_pkg::OP_LOAD;
                    op_next    = kabf_pkg::OP_PRED_A;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.op  = op_reg;
                op_next = kabf_pkg::op_t'(op_reg + 5'd1);
                if (op_reg == kabf_pkg::OP_DIV0 || op_reg == kabf_pkg::OP_DIV1)
                    state_next = ST_WAIT;
                else if (op_reg == kabf_pkg::OP_C11)
                    state_next = ST_DONE;
            end
            ST_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = ST_STEP;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op     = kabf_pkg::OP_COMMIT;
                    ov_next    = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= kabf_pkg::OP_NONE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

@@ src/kalman_angle_bias_filter.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state kalman filter: tilt angle and gyro bias in fixed point
// ----------------------------------------------------------------------------
// timing: a request runs 15 sequencing steps, two waits on the shared bit-serial
// divider and the commit before its result is out
// flow: one request in flight, a new one is taken only once the last is done; a stalled
// result holds the commit of the next one
// reset: angle and bias zero, covariance identity, noise registers at defaults
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter
#(
    parameter int VALUE_WIDTH = kabf_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kabf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [kabf_pkg::REG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             measured_angle,
    input  logic signed [31:0]             gyro_rate,
    input  logic [23:0]                    time_step,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             angle_estimate,
    output logic signed [31:0]             bias_estimate,
    output logic                           saturated
);

    // command and status between sequencer and datapath
    kabf_pkg::dp_cmd_t  cmd;
    kabf_pkg::dp_stat_t stat;

    // sequencer: accepts a request, steps the datapath, hands off the result
    kabf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: filter state, one shared multiplier, one serial divider
    kabf_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .time_step      (time_step),
        .angle_estimate (angle_estimate),
        .bias_estimate  (bias_estimate),
        .saturated      (saturated)
    );

    // the result register is only loaded while the old result is gone or taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(angle_estimate))
        else $error("result overwritten while stalled");

    // no new request is taken while a divide is running
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> !in_ready)
        else $error("request accepted during divide");

    // out_valid does not rise right after a request is accepted
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid || $past(out_valid, 1))
        else $error("result appeared too early");

endmodule
